[sv/ethms_pkg.sv]
`default_nettype none
package ethms_pkg;

  // ascii codes for the emitted text
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_H    = 8'd104;
  localparam logic [7:0] CHAR_M    = 8'd109;
  localparam logic [7:0] CHAR_S    = 8'd115;

  // depth of the queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // decimal digits of one time, most significant first
  typedef struct packed {
    logic [3:0] h3;
    logic [3:0] h2;
    logic [3:0] h1;
    logic [3:0] h0;
    logic [3:0] m1;
    logic [3:0] m0;
    logic [3:0] s1;
    logic [3:0] s0;
  } hms_digits_t;

  // text sequencer phases
  typedef enum logic [2:0] {
    ST_LEAD,
    ST_HOURS,
    ST_HUNIT,
    ST_MINS,
    ST_MUNIT,
    ST_SECS,
    ST_SUNIT
  } seq_state_t;

endpackage
`default_nettype wire

[sv/ethms_front.sv]
`default_nettype none
module ethms_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [30:0]          in_ticks,
  output logic                      q_push,
  input  wire logic                 q_full,
  output ethms_pkg::hms_digits_t    q_data
);

  // reciprocals for exact division by 15 after a shift by 2, and by 1000 / 100 / 10
  localparam logic [31:0] RCP1 = 32'd2290649225; // 2^35 / 15
  localparam logic [25:0] RCP2 = 26'd35791395;   // 2^29 / 15
  localparam logic [19:0] RCP3 = 20'd559241;     // 2^23 / 15
  localparam logic [14:0] RCP_K = 15'd16778;     // 2^24 / 1000
  localparam logic [10:0] RCP_C = 11'd1311;      // 2^17 / 100
  localparam logic [7:0]  RCP_D = 8'd205;        // 2^11 / 10

  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7, v8;

  logic [31:0] s1_sum;
  logic [61:0] s2_prod;
  logic [5:0]  s3_q1;
  logic [49:0] s3_prod;
  logic [5:0]  s4_q2, s4_secs;
  logic [37:0] s4_prod;
  logic [13:0] s5_hrs;
  logic [28:0] s5_prod;
  logic [5:0]  s5_mins, s5_secs;
  logic [3:0]  s6_d3;
  logic [9:0]  s6_r;
  logic [5:0]  s6_mins, s6_secs;
  logic [3:0]  s7_d3;
  logic [9:0]  s7_r;
  logic [20:0] s7_prod;
  logic [5:0]  s7_mins, s7_secs;
  logic [3:0]  s8_d3, s8_d2;
  logic [6:0]  s8_r2;
  logic [5:0]  s8_mins, s8_secs;

  logic [25:0] q1_w;
  logic [19:0] q2_w;
  logic [13:0] hrs_w;
  logic [3:0]  d3_w, d2_w;
  logic [13:0] r_full;
  logic [9:0]  r2_full;

  // whole pipeline holds while the last stage cannot enter the queue
  assign adv     = !(v8 && q_full);
  assign in_full = !adv;
  assign q_push  = v8 && adv;

  assign q1_w    = s2_prod[60:35];
  assign q2_w    = s3_prod[48:29];
  assign hrs_w   = s4_prod[36:23];
  assign d3_w    = s5_prod[27:24];
  assign r_full  = s5_hrs - (14'(s5_prod[27:24]) * 14'd1000);
  assign d2_w    = s7_prod[20:17];
  assign r2_full = s7_r - (10'(d2_w) * 10'd100);

  // tens digit of a value below 100
  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'(RCP_D);
    return p[14:11];
  endfunction

  // ones digit of a value below 100
  function automatic logic [3:0] ones_of(input logic [6:0] x);
    logic [6:0] t;
    t = 7'(tens_of(x)) * 7'd10;
    return 4'(x - t);
  endfunction

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
    end else if (adv) begin
      v1 <= in_push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  // datapath stages: round, three divisions by 60 steps, hour digits
  // remainders x - 60q come from the low bits as x + 4q mod 64
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum  <= {1'b0, in_ticks} + 32'd30;

      s2_prod <= 62'(s1_sum[31:2]) * 62'(RCP1);

      s3_q1   <= q1_w[5:0];
      s3_prod <= 50'(q1_w[25:2]) * 50'(RCP2);

      s4_q2   <= q2_w[5:0];
      s4_secs <= s3_q1 + {q2_w[3:0], 2'b00};
      s4_prod <= 38'(q2_w[19:2]) * 38'(RCP3);

      s5_hrs  <= hrs_w;
      s5_prod <= 29'(hrs_w) * 29'(RCP_K);
      s5_mins <= s4_q2 + {hrs_w[3:0], 2'b00};
      s5_secs <= s4_secs;

      s6_d3   <= d3_w;
      s6_r    <= r_full[9:0];
      s6_mins <= s5_mins;
      s6_secs <= s5_secs;

      s7_d3   <= s6_d3;
      s7_r    <= s6_r;
      s7_prod <= 21'(s6_r) * 21'(RCP_C);
      s7_mins <= s6_mins;
      s7_secs <= s6_secs;

      s8_d3   <= s7_d3;
      s8_d2   <= d2_w;
      s8_r2   <= r2_full[6:0];
      s8_mins <= s7_mins;
      s8_secs <= s7_secs;
    end
  end

  // final digit split into the queue entry
  always_comb begin
    q_data.h3 = s8_d3;
    q_data.h2 = s8_d2;
    q_data.h1 = tens_of(s8_r2);
    q_data.h0 = ones_of(s8_r2);
    q_data.m1 = tens_of({1'b0, s8_mins});
    q_data.m0 = ones_of({1'b0, s8_mins});
    q_data.s1 = tens_of({1'b0, s8_secs});
    q_data.s0 = ones_of({1'b0, s8_secs});
  end

endmodule
`default_nettype wire

[sv/ethms_fifo.sv]
`default_nettype none
module ethms_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  ethms_pkg::hms_digits_t    wdata,
  output logic                      full,
  input  wire logic                 pop,
  output ethms_pkg::hms_digits_t    rdata,
  output logic                      empty
);

  ethms_pkg::hms_digits_t mem [ethms_pkg::FIFO_DEPTH];
  logic [ethms_pkg::FIFO_AW-1:0] wptr, rptr;
  logic [ethms_pkg::FIFO_AW:0]   count;
  logic do_push, do_pop;

  assign full    = (count == (ethms_pkg::FIFO_AW+1)'(ethms_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

endmodule
`default_nettype wire

[sv/ethms_back.sv]
`default_nettype none
module ethms_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  ethms_pkg::hms_digits_t    head,
  input  wire logic                 head_empty,
  output logic                      head_pop,
  output logic [7:0]                char_code,
  output logic                      last,
  output logic                      empty,
  input  wire logic                 pop
);

  ethms_pkg::seq_state_t state, state_next, eff_state;
  logic [1:0] idx, idx_next, eff_idx;
  logic       out_valid;
  logic       fire;
  logic       hrs_nz;
  logic [1:0] h_start;
  logic [3:0] digit;
  logic [7:0] ch;
  logic       is_last;

  assign empty  = !out_valid;
  assign fire   = !head_empty && (!out_valid || pop);
  assign hrs_nz = (head.h3 != 4'd0) || (head.h2 != 4'd0) ||
                  (head.h1 != 4'd0) || (head.h0 != 4'd0);

  // first hour digit without leading zeros
  always_comb begin
    if (head.h3 != 4'd0)      h_start = 2'd0;
    else if (head.h2 != 4'd0) h_start = 2'd1;
    else if (head.h1 != 4'd0) h_start = 2'd2;
    else                      h_start = 2'd3;
  end

  // sequencer: pick the character and the next position
  always_comb begin
    eff_state = state;
    eff_idx   = idx;
    if (state == ethms_pkg::ST_LEAD) begin
      if (hrs_nz) begin
        eff_state = ethms_pkg::ST_HOURS;
        eff_idx   = h_start;
      end else begin
        eff_state = ethms_pkg::ST_MINS;
        eff_idx   = (head.m1 != 4'd0) ? 2'd0 : 2'd1;
      end
    end

    digit      = 4'd0;
    ch         = ethms_pkg::CHAR_S;
    is_last    = 1'b0;
    state_next = eff_state;
    idx_next   = eff_idx;
    case (eff_state)
      ethms_pkg::ST_HOURS: begin
        case (eff_idx)
          2'd0:    digit = head.h3;
          2'd1:    digit = head.h2;
          2'd2:    digit = head.h1;
          default: digit = head.h0;
        endcase
        ch = ethms_pkg::CHAR_ZERO + {4'd0, digit};
        if (eff_idx == 2'd3) state_next = ethms_pkg::ST_HUNIT;
        else idx_next = eff_idx + 2'd1;
      end
      ethms_pkg::ST_HUNIT: begin
        ch         = ethms_pkg::CHAR_H;
        state_next = ethms_pkg::ST_MINS;
        idx_next   = (head.m1 != 4'd0) ? 2'd0 : 2'd1;
      end
      ethms_pkg::ST_MINS: begin
        digit = (eff_idx == 2'd0) ? head.m1 : head.m0;
        ch    = ethms_pkg::CHAR_ZERO + {4'd0, digit};
        if (eff_idx == 2'd0) idx_next = 2'd1;
        else state_next = ethms_pkg::ST_MUNIT;
      end
      ethms_pkg::ST_MUNIT: begin
        ch         = ethms_pkg::CHAR_M;
        state_next = ethms_pkg::ST_SECS;
        idx_next   = (head.s1 != 4'd0) ? 2'd0 : 2'd1;
      end
      ethms_pkg::ST_SECS: begin
        digit = (eff_idx == 2'd0) ? head.s1 : head.s0;
        ch    = ethms_pkg::CHAR_ZERO + {4'd0, digit};
        if (eff_idx == 2'd0) idx_next = 2'd1;
        else state_next = ethms_pkg::ST_SUNIT;
      end
      ethms_pkg::ST_SUNIT: begin
        ch         = ethms_pkg::CHAR_S;
        is_last    = 1'b1;
        state_next = ethms_pkg::ST_LEAD;
        idx_next   = 2'd0;
      end
      default: begin
        state_next = ethms_pkg::ST_LEAD;
        idx_next   = 2'd0;
      end
    endcase
  end

  assign head_pop = fire && is_last;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ethms_pkg::ST_LEAD;
      idx   <= 2'd0;
    end else if (fire) begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      char_code <= ch;
      last      <= is_last;
    end
  end

endmodule
`default_nettype wire

[sv/elapsed_ticks_to_hms_text_unit.sv]
// Elapsed time formatter: ticks at 60 Hz in, ASCII text such as "1h2m3s" out.
// Input channel: drive ticks with push; the item transfers on a clock edge
// where push is high and full is low.
// Result channel: while empty is low, char_code and last show the oldest
// character; it transfers on a clock edge where pop is high. One time gives
// 4 to 11 characters, hour part only when nonzero, last high on the 's'.
// A time passes through the 8-stage arithmetic pipeline, the queue and the
// output register before its first character is on the ports.
// The character sequencer gives one character per cycle while the queue
// holds a time and the receiver pops; a time has at most 11 characters.
// The front pipeline keeps accepting times while the back is busy, until its
// 4-entry queue is full and a time waits at the pipeline end; then full rises.
// A stalled receiver holds the current character on the ports and backs up
// the queue and then the input side. Synchronous reset empties the pipeline,
// the queue and the output register; no clearing pass is needed.
`default_nettype none
module elapsed_ticks_to_hms_text_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [30:0] ticks,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       char_code,
  output logic             last
);

  ethms_pkg::hms_digits_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_empty;

  // rounding, division and digit split
  ethms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_push  (push),
    .in_full  (full),
    .in_ticks (ticks),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_wdata)
  );

  // decoupling queue
  ethms_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // character sequencer
  ethms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_rdata),
    .head_empty (q_empty),
    .head_pop   (q_pop),
    .char_code  (char_code),
    .last       (last),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
`default_nettype wire

[verif/elapsed_ticks_to_hms_text_unit_tb.sv]
`default_nettype none
module elapsed_ticks_to_hms_text_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted character of the text
  typedef struct {
    logic [7:0] code;
    logic       tail;
  } text_char_t;

  // predicts the text of each time and checks characters in order
  class hms_text_scoreboard;
    text_char_t pending_chars[$];
    int         mismatches;
    int         times_seen;
    int         hour_times;
    int         chars_checked;

    function new();
      mismatches    = 0;
      times_seen    = 0;
      hour_times    = 0;
      chars_checked = 0;
    endfunction

    function void add_char(logic [7:0] code, logic tail);
      text_char_t c;
      c.code = code;
      c.tail = tail;
      pending_chars.push_back(c);
    endfunction

    // decimal digits with no leading zeros, at least one digit
    function void add_number(int unsigned v);
      int unsigned div;
      int unsigned d;
      bit          started;
      started = 0;
      for (div = 1000; div != 1; div = div / 10) begin
        d = v / div;
        if (d != 0) started = 1;
        if (started) add_char(ethms_pkg::CHAR_ZERO + 8'(d % 10), 1'b0);
        v = v % div;
      end
      add_char(ethms_pkg::CHAR_ZERO + 8'(v), 1'b0);
    endfunction

    // note an accepted time and append its predicted text
    function void note_time(logic [30:0] t);
      logic [31:0] rounded;
      int unsigned total_s;
      int unsigned secs;
      int unsigned mins;
      int unsigned hrs;
      rounded = {1'b0, t} + 32'd30;
      total_s = rounded / 60;
      secs    = total_s % 60;
      mins    = (total_s / 60) % 60;
      hrs     = total_s / 3600;
      times_seen++;
      if (hrs != 0) begin
        hour_times++;
        add_number(hrs);
        add_char(ethms_pkg::CHAR_H, 1'b0);
      end
      add_number(mins);
      add_char(ethms_pkg::CHAR_M, 1'b0);
      add_number(secs);
      add_char(ethms_pkg::CHAR_S, 1'b1);
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // compare one transferred character with the oldest prediction
    function void check_char(logic [7:0] code, logic tail);
      text_char_t want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b", code, tail));
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("char_code expected 0x%02h got 0x%02h",
                                  want.code, code));
      if (tail !== want.tail)
        report_mismatch($sformatf("last expected %0b got %0b (char 0x%02h)",
                                  want.tail, tail, want.code));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [30:0] ticks;
  logic        empty;
  logic        pop;
  logic [7:0]  char_code;
  logic        last;

  int sender_idle_pct;
  int receiver_stall_pct;

  hms_text_scoreboard sb = new();

  elapsed_ticks_to_hms_text_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .ticks     (ticks),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code),
    .last      (last)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // transfer monitors, values sampled before the edge updates
  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_time(ticks);
    if (!rst && pop && !empty) sb.check_char(char_code, last);
  end

  // receiver with random stalls
  initial pop = 1'b0;
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // present one time and hold it until its transfer, returns at a falling edge
  task automatic send_time(input logic [30:0] t);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push  <= 1'b1;
    ticks <= t;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // random time shaped toward rounding, minute and hour boundaries
  function automatic logic [30:0] random_ticks();
    int unsigned v;
    case ($urandom_range(5))
      0: v = $urandom() & 32'h7FFF_FFFF;
      1: v = $urandom_range(216029, 0);
      2: v = $urandom_range(2160000, 0);
      3: v = $urandom_range(35791393, 0) * 60 + 29 + $urandom_range(1);
      4: v = $urandom_range(596522, 1) * 3600 - 30 + $urandom_range(60);
      default: v = $urandom_range(9941, 1) * 216000 - 30 + $urandom_range(60);
    endcase
    return v[30:0];
  endfunction

  logic [30:0] directed_times[$] = '{
    31'd0, 31'd29, 31'd30, 31'd89, 31'd90, 31'd3569, 31'd3570,
    31'd215969, 31'd215970, 31'd216000, 31'd2159970, 31'd2160000,
    31'd21600000, 31'd216000000, 31'd2147483617, 31'd2147483618,
    31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA, 31'd38, 31'd600
  };

  // main sequence
  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle         = '{0, 58, 0, 23};
    phase_stall        = '{0, 0, 58, 23};
    rst                = 1'b1;
    push               = 1'b0;
    ticks              = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_times[i]) send_time(directed_times[i]);
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = phase_idle[p];
      receiver_stall_pct = phase_stall[p];
      repeat (90) send_time(random_ticks());
    end
    push <= 1'b0;

    // drain the text still owed, then let the pipeline settle
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d times (%0d with hours) and %0d characters", sb.times_seen,
             sb.hour_times, sb.chars_checked);
    $display("idling phases: none, sender idle, receiver stall, both");
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d characters never seen", sb.mismatches,
               sb.pending_chars.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d characters outstanding", sb.pending_chars.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
